### hw/rtl/kesd_pkg.sv
// Shared types and constants of the key escape string decoder.
// No dependencies; imported by kesd_step and key_escape_string_decoder.
`default_nettype none

package kesd_pkg;

  localparam int unsigned KESD_FIFO_DEPTH = 4;

  localparam logic [1:0] MODE_ECHO = 2'd0;
  localparam logic [1:0] MODE_KEY  = 2'd2;
  localparam logic [1:0] MODE_BAD  = 2'd3;

  localparam logic [7:0] CH_BSL    = 8'h5c;
  localparam logic [7:0] CH_CARET  = 8'h5e;
  localparam logic [7:0] CH_DASH   = 8'h2d;
  localparam logic [7:0] CH_QMARK  = 8'h3f;
  localparam logic [7:0] CH_ESC    = 8'h1b;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_DEL    = 8'h7f;
  localparam logic [7:0] CTRL_MASK = 8'h9f;
  localparam logic [7:0] META_BIT  = 8'h80;

  localparam logic [1:0] META_NONE  = 2'd0;
  localparam logic [1:0] META_FIRST = 2'd1;
  localparam logic [1:0] META_LATE  = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_BSL,
    PH_META,
    PH_CTRL,
    PH_OCT,
    PH_HEX
  } kesd_phase_e;

  typedef struct packed {
    kesd_phase_e phase;
    logic [1:0]  digit_count;
    logic [8:0]  number_value;
    logic [1:0]  meta_pending;
    logic        control_pending;
    logic        stop_flag;
  } kesd_state_t;

  localparam kesd_state_t KESD_STATE_RESET = '{PH_IDLE, 2'd0, 9'd0, META_NONE, 1'b0, 1'b0};

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       string_done;
    logic       stop_seen;
  } kesd_beat_t;

  typedef struct packed {
    logic [1:0] count;
    kesd_beat_t beat0;
    kesd_beat_t beat1;
  } kesd_step_t;

endpackage

`default_nettype wire

### hw/rtl/kesd_step.sv
// One decode step: current string state and one character in, next state and
// up to two output beats out. Purely combinational; depends on kesd_pkg.
`default_nettype none

module kesd_step (
  input  logic [1:0]          mode_i,
  input  kesd_pkg::kesd_state_t state_i,
  input  logic [7:0]          in_char_i,
  input  logic                is_last_i,
  output kesd_pkg::kesd_state_t state_o,
  output kesd_pkg::kesd_step_t  step_o
);
  import kesd_pkg::*;

  typedef struct packed {
    logic [1:0] cnt;
    logic [7:0] b0;
    logic [7:0] b1;
  } ebuf_t;

  function automatic ebuf_t push(ebuf_t eb, logic [7:0] x);
    ebuf_t r;
    r = eb;
    if (eb.cnt == 2'd0) begin
      r.b0  = x;
      r.cnt = 2'd1;
    end else if (eb.cnt == 2'd1) begin
      r.b1  = x;
      r.cnt = 2'd2;
    end
    return r;
  endfunction

  function automatic logic [7:0] mod_byte(logic [7:0] b, logic [1:0] mp, logic cp);
    logic [7:0] t;
    t = b;
    if (mp == META_LATE) t = t | META_BIT;
    if (cp) t = (t == CH_QMARK) ? CH_DEL : (t & CTRL_MASK);
    if (mp == META_FIRST) t = t | META_BIT;
    return t;
  endfunction

  function automatic logic [8:0] letter_code(logic [7:0] c);
    logic [8:0] r;
    case (c)
      "a":     r = {1'b1, 8'h07};
      "b":     r = {1'b1, CH_BS};
      "t":     r = {1'b1, 8'h09};
      "n":     r = {1'b1, 8'h0a};
      "v":     r = {1'b1, 8'h0b};
      "f":     r = {1'b1, 8'h0c};
      "r":     r = {1'b1, 8'h0d};
      "e":     r = {1'b1, CH_ESC};
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] hex_digit(logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c inside {["0":"9"]}) r = {1'b1, c[3:0]};
    else if (c inside {["a":"f"], ["A":"F"]}) r = {1'b1, c[3:0] + 4'd9};
    return r;
  endfunction

  logic [1:0]  mode;
  logic [7:0]  c;
  logic        last;
  kesd_phase_e ph;
  logic [1:0]  dc;
  logic [8:0]  nv;
  logic [1:0]  mp;
  logic        cp;
  logic        sf;
  ebuf_t       eb;
  logic        do_plain;
  logic [8:0]  letter;
  logic        is_hex;
  logic [1:0]  maxd;
  logic [4:0]  dig;
  logic        empty;

  always_comb begin
    mode     = (mode_i == MODE_BAD) ? MODE_KEY : mode_i;
    c        = in_char_i;
    last     = is_last_i;
    ph       = state_i.phase;
    dc       = state_i.digit_count;
    nv       = state_i.number_value;
    mp       = state_i.meta_pending;
    cp       = state_i.control_pending;
    sf       = state_i.stop_flag;
    eb       = '0;
    do_plain = 1'b0;
    letter   = letter_code(c);
    is_hex   = (state_i.phase == PH_HEX);
    maxd     = is_hex ? 2'd2 : 2'd3;
    dig      = is_hex ? hex_digit(c) : {(c inside {["0":"7"]}), 1'b0, c[2:0]};

    case (state_i.phase)
      PH_BSL: begin
        ph = PH_IDLE;
        if (letter[8]) begin
          eb = push(eb, mod_byte(letter[7:0], mp, cp));
          mp = META_NONE;
          cp = 1'b0;
        end else if (mode == MODE_ECHO &&
                     (c inside {"E", "M", "C", ["1":"7"]})) begin
          eb       = push(eb, CH_BSL);
          do_plain = 1'b1;
        end else if (c == "E") begin
          eb = push(eb, mod_byte(CH_ESC, mp, cp));
          mp = META_NONE;
          cp = 1'b0;
        end else if (c == "M") begin
          mp = cp ? META_LATE : META_FIRST;
          ph = PH_META;
        end else if (c == "C") begin
          cp = 1'b1;
          ph = PH_CTRL;
        end else if (c == "c" && mode != MODE_KEY) begin
          sf = 1'b1;
        end else if (c inside {["0":"7"], "x"}) begin
          if (c == "x") begin
            ph = PH_HEX;
            nv = 9'd0;
            dc = 2'd0;
          end else if (mode == MODE_ECHO) begin
            ph = PH_OCT;
            nv = 9'd0;
            dc = 2'd0;
          end else begin
            ph = PH_OCT;
            nv = {6'd0, c[2:0]};
            dc = 2'd1;
          end
          if (last) begin
            eb = push(eb, mod_byte(nv[7:0], mp, cp));
            mp = META_NONE;
            cp = 1'b0;
            ph = PH_IDLE;
            dc = 2'd0;
            nv = 9'd0;
          end
        end else begin
          if (mode == MODE_ECHO && c != CH_BSL) eb = push(eb, CH_BSL);
          eb = push(eb, mod_byte(c, mp, cp));
          mp = META_NONE;
          cp = 1'b0;
        end
      end
      PH_META, PH_CTRL: begin
        if (c == CH_DASH) ph = PH_IDLE;
        else do_plain = 1'b1;
      end
      PH_OCT, PH_HEX: begin
        if (dig[4] && dc < maxd) begin
          nv = is_hex ? {nv[4:0], dig[3:0]} : {nv[5:0], dig[2:0]};
          dc = dc + 2'd1;
          if (dc >= maxd || last) begin
            eb = push(eb, mod_byte(nv[7:0], mp, cp));
            mp = META_NONE;
            cp = 1'b0;
            ph = PH_IDLE;
            dc = 2'd0;
            nv = 9'd0;
          end
        end else begin
          eb = push(eb, mod_byte(nv[7:0], mp, cp));
          mp = META_NONE;
          cp = 1'b0;
          ph = PH_IDLE;
          dc = 2'd0;
          nv = 9'd0;
          do_plain = 1'b1;
        end
      end
      default: begin
        do_plain = 1'b1;
      end
    endcase

    if (do_plain) begin
      ph = PH_IDLE;
      if (c == CH_BSL) begin
        if (last) begin
          eb = push(eb, mod_byte(c, mp, cp));
          mp = META_NONE;
          cp = 1'b0;
        end else begin
          ph = PH_BSL;
        end
      end else if (c == CH_CARET && mode == MODE_KEY) begin
        cp = 1'b1;
      end else begin
        eb = push(eb, mod_byte(c, mp, cp));
        mp = META_NONE;
        cp = 1'b0;
      end
    end

    empty = last && (eb.cnt == 2'd0);

    step_o.count             = empty ? 2'd1 : eb.cnt;
    step_o.beat0.out_byte    = empty ? 8'd0 : eb.b0;
    step_o.beat0.byte_valid  = !empty;
    step_o.beat0.run_last    = (eb.cnt != 2'd2);
    step_o.beat0.string_done = last && (eb.cnt != 2'd2);
    step_o.beat0.stop_seen   = sf;
    step_o.beat1.out_byte    = eb.b1;
    step_o.beat1.byte_valid  = 1'b1;
    step_o.beat1.run_last    = 1'b1;
    step_o.beat1.string_done = last;
    step_o.beat1.stop_seen   = sf;

    if (last) begin
      state_o = KESD_STATE_RESET;
    end else begin
      state_o = '{ph, dc, nv, mp, cp, sf};
    end
  end

endmodule

`default_nettype wire

### hw/rtl/key_escape_string_decoder.sv
// Top level of the key escape string decoder: string state, mode register and
// output beat queue. Depends on kesd_pkg and kesd_step.
//
// Takes one character per cycle and decodes it in the same cycle against the
// registered string state; the decoded bytes (zero, one or two per character)
// go into a queue of FifoDepth beats that drives the output port, one beat per
// cycle while out_stall_i is low. The input stalls while fewer than two
// queue slots are free, so a character that decodes to two bytes fills two
// output beats; rate: one character per cycle up to one output beat per cycle.
// source_mode is written through the cfg port, which is always ready; write it
// only while no string is in progress. Reset value of source_mode is 2.
`default_nettype none

module key_escape_string_decoder #(
  parameter int unsigned FifoDepth = kesd_pkg::KESD_FIFO_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_char_i,
  input  logic       is_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       run_last_o,
  output logic       string_done_o,
  output logic       stop_seen_o
);
  import kesd_pkg::*;

  localparam int unsigned AW = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned CW = $clog2(FifoDepth + 1);

  logic [1:0]  mode_q;
  kesd_state_t state_q;
  kesd_state_t state_d;
  kesd_step_t  step;

  kesd_beat_t  mem_q [FifoDepth];
  logic [AW-1:0] wr_q;
  logic [AW-1:0] wr_d;
  logic [AW-1:0] wr_nx1;
  logic [AW-1:0] wr_nx2;
  logic [AW-1:0] rd_q;
  logic [AW-1:0] rd_d;
  logic [CW-1:0] cnt_q;
  logic [CW-1:0] cnt_d;
  logic [1:0]    push_n;
  logic          in_acc;
  logic          out_acc;

  kesd_step u_step (
    .mode_i    (mode_q),
    .state_i   (state_q),
    .in_char_i (in_char_i),
    .is_last_i (is_last_i),
    .state_o   (state_d),
    .step_o    (step)
  );

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (cnt_q > CW'(FifoDepth - 2));
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = (cnt_q != '0);
  assign out_acc     = out_valid_o && !out_stall_i;

  assign push_n = in_acc ? step.count : 2'd0;
  assign wr_nx1 = (wr_q == AW'(FifoDepth - 1)) ? '0 : wr_q + 1'b1;
  assign wr_nx2 = (wr_nx1 == AW'(FifoDepth - 1)) ? '0 : wr_nx1 + 1'b1;

  always_comb begin
    case (push_n)
      2'd1:    wr_d = wr_nx1;
      2'd2:    wr_d = wr_nx2;
      default: wr_d = wr_q;
    endcase
    rd_d = rd_q;
    if (out_acc) rd_d = (rd_q == AW'(FifoDepth - 1)) ? '0 : rd_q + 1'b1;
    cnt_d = cnt_q + CW'(push_n) - CW'(out_acc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_KEY;
      state_q <= KESD_STATE_RESET;
      wr_q    <= '0;
      rd_q    <= '0;
      cnt_q   <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) mode_q <= cfg_data_i;
      if (in_acc) state_q <= state_d;
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) mem_q[wr_q] <= step.beat0;
    if (push_n == 2'd2) mem_q[wr_nx1] <= step.beat1;
  end

  assign out_byte_o    = mem_q[rd_q].out_byte;
  assign byte_valid_o  = mem_q[rd_q].byte_valid;
  assign run_last_o    = mem_q[rd_q].run_last;
  assign string_done_o = mem_q[rd_q].string_done;
  assign stop_seen_o   = mem_q[rd_q].stop_seen;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(FifoDepth))
    else $error("beat queue overflow");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && is_last_i |=> state_q.phase == PH_IDLE && !state_q.stop_flag &&
                            state_q.meta_pending == META_NONE &&
                            !state_q.control_pending)
    else $error("string state not cleared after last character");

  a_last_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && is_last_i |=> out_valid_o)
    else $error("last character produced no beat");

  a_done_is_run_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && string_done_o |-> run_last_o)
    else $error("string_done beat without run_last");
`endif

endmodule

`default_nettype wire
